>>> sv/dhad_pkg.sv
// Shared types, constants and helpers for the duplicate address detector.
`default_nettype none

package dhad_pkg;

  localparam int ADDR_W  = 64;
  localparam int CMP_W   = 4;
  localparam int COUNT_W = 7;
  localparam int OUT_W   = 16;
  localparam logic [CMP_W-1:0] CMP_RESET = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Probe token handed from cell to cell.
  typedef struct packed {
    logic act;
    logic hit;
  } probe_t;

  // Byte mask for a compare length; zero acts as one, above eight as eight.
  function automatic logic [ADDR_W-1:0] byte_mask(input logic [CMP_W-1:0] n);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b == 0 || CMP_W'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/dhad_cell.sv
// One table slot: holds an address, compares it with the probe and passes the token on.
`default_nettype none

module dhad_cell
  import dhad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ADDR_W-1:0] probe_addr,
  input  wire logic [ADDR_W-1:0] mask,
  input  wire probe_t            probe_in,
  output probe_t                 probe_out
);

  logic [ADDR_W-1:0] entry_r;
  logic              valid_r;
  logic              valid_nxt;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic              match;

  assign match = valid_r && ((entry_r & mask) == probe_addr);

  always_comb begin
    probe_nxt.act = probe_in.act;
    probe_nxt.hit = probe_in.act && (probe_in.hit || match);
    valid_nxt     = valid_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (wr_en) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_addr;
    end
  end

  assign probe_out = probe_r;

endmodule

`default_nettype wire

>>> sv/duplicate_hw_address_detector_core.sv
// Top level: duplicate hardware address detector built on a chain of slot cells.
//
//  channel | ports               | contents
//  --------+---------------------+------------------------------------------
//  in      | in_tvalid/in_tready | tuser: action; tdata: hw_addr
//  out     | out_tvalid/tready   | tdata: duplicate, stored, overflow, count
//  cfg     | cfg_wr_en           | cfg_wr_data: compare_bytes
//
// A check word's result becomes valid once, after accept, the probe has walked the cell
// chain one slot per cycle, its hit has been registered and the insert decision commits;
// the next word is accepted after the commit returns the sequencer to idle.
// An end-of-scan word skips the chain and goes straight to commit; its result is
// registered there, and the commit clears every slot at once.
// One word is in flight at a time; a waiting result holds the commit step.
// Reset (rst_n low, synchronous) empties the table and sets compare_bytes to 6.
`default_nettype none

module duplicate_hw_address_detector_core
  import dhad_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ADDR_W-1:0] in_tdata,   // [63:0] hw_addr
  input  wire logic [0:0]        in_tuser,   // [0] action
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // [0] duplicate, [1] stored,
                                             // [2] overflow, [9:3] entry_count
  input  wire logic              cfg_wr_en,
  input  wire logic [CMP_W-1:0]  cfg_wr_data // [3:0] compare_bytes
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t            state_r, state_nxt;
  logic [CMP_W-1:0]  cmp_r;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] addr_r;
  logic              clr_pend_r;
  logic              start_r;
  logic              hit_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              accept;
  logic              commit;
  logic              slot_free;
  logic              do_clr;
  logic              do_wr;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;
  probe_t            chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] wr_sel;

  assign mask      = byte_mask(cmp_r);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = in_tuser[0] ? ST_FIN : ST_SCAN;
      ST_SCAN: if (chain[TABLE_ENTRIES].act) state_nxt = ST_FIN;
      ST_FIN:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: ;
      ST_FIN:  commit = slot_free;
      default: ;
    endcase
  end

  // Commit: clear, flag duplicate, insert at the next free slot or flag overflow.
  always_comb begin
    do_clr       = 1'b0;
    do_wr        = 1'b0;
    cnt_nxt      = cnt_r;
    out_data_nxt = '0;
    if (commit) begin
      if (clr_pend_r) begin
        do_clr  = 1'b1;
        cnt_nxt = '0;
      end else if (hit_r) begin
        out_data_nxt[0] = 1'b1;
      end else if (cnt_r != CNT_W'(TABLE_ENTRIES)) begin
        do_wr           = 1'b1;
        cnt_nxt         = cnt_r + CNT_W'(1);
        out_data_nxt[1] = 1'b1;
      end else begin
        out_data_nxt[2] = 1'b1;
      end
    end
    cnt_wide = {{COUNT_W{1'b0}}, cnt_nxt};
    out_data_nxt[3 +: COUNT_W] = cnt_wide[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_r       <= CMP_RESET;
      start_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept && !in_tuser[0];
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        cmp_r <= cfg_wr_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r     <= in_tdata & mask;
      clr_pend_r <= in_tuser[0];
    end
    if (chain[TABLE_ENTRIES].act) begin
      hit_r <= chain[TABLE_ENTRIES].hit;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign chain[0].act = start_r;
  assign chain[0].hit = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign wr_sel[i] = do_wr && (cnt_r == CNT_W'(i));

    dhad_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr        (do_clr),
      .wr_en      (wr_sel[i]),
      .wr_addr    (addr_r),
      .probe_addr (addr_r),
      .mask       (mask),
      .probe_in   (chain[i]),
      .probe_out  (chain[i+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
